/* design/ilir_pkg.sv */
// Package for the indexed list core: payload structs, request and status codes,
// and the control word broadcast to the storage cells. No dependencies.

package ilir_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int WORD_W       = 32;
  localparam int POS_W        = 8;
  // wide enough for any count, position or capacity compare
  localparam int EXT_W        = 9;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_WRITE  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;
  localparam logic [2:0] REQ_CLEAR  = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               req_type;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] element_value;
    logic [7:0]               remove_count;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_word;
    logic [4:0]               length_now;
    logic                     is_empty;
    logic [1:0]               status;
  } res_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] data;
  } cell_ctrl_t;

endpackage

/* design/indexed_list_insert_remove_core.sv */
// Top level of the indexed list core: request decode, length counter, removal
// sequencer and the chain of storage cells. Uses ilir_pkg and ilir_cell.
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+----------------------------------
//  request  | start, busy, req_i         | transfer when start && !busy
//  result   | res_valid_o, res_o         | one-cycle strobe, always taken
//
// Every request gives its result in the cycle after the transfer. Append, insert,
// write, read and clear leave busy low, so a new request may follow at once.
// A removal of k entries (after cutting at the end) shifts the cell chain down
// one slot a cycle and holds busy high until all k shift steps are done.
// Reset clears the length and the sequencer; slot contents are not reset.

module indexed_list_insert_remove_core #(
  parameter int CAPACITY = ilir_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ilir_pkg::req_t req_i,
  output logic           res_valid_o,
  output ilir_pkg::res_t res_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = ilir_pkg::EXT_W;
  localparam int WORD_W = ilir_pkg::WORD_W;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SHIFT = 2'b10
  } state_e;

  state_e     state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [ilir_pkg::POS_W-1:0] shpos_q, shpos_d;
  logic       res_valid_q;
  ilir_pkg::res_t res_q, res_d;

  ilir_pkg::cell_ctrl_t ctrl;
  logic [WORD_W-1:0] words    [CAPACITY];
  logic [WORD_W-1:0] rd_words [CAPACITY];
  logic [WORD_W-1:0] rd_bus;

  logic             take;
  logic [EXT_W-1:0] cnt_x, pos_x, rc_x, avail, k_x, cap_x;
  logic             full;

  assign take  = start && !busy;
  assign busy  = (state_q == S_SHIFT);
  assign cnt_x = EXT_W'(count_q);
  assign pos_x = EXT_W'(req_i.position);
  assign rc_x  = EXT_W'(req_i.remove_count);
  assign cap_x = EXT_W'(CAPACITY);
  assign full  = (cnt_x >= cap_x);
  assign avail = cnt_x - pos_x;
  assign k_x   = (rc_x > avail) ? avail : rc_x;

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | rd_words[i];
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rem_d     = rem_q;
    shpos_d   = shpos_q;
    ctrl.op   = ilir_pkg::OP_HOLD;
    ctrl.pos  = req_i.position;
    ctrl.data = req_i.element_value;
    res_d.read_word = '0;
    res_d.status    = ilir_pkg::ST_DONE;

    if (state_q == S_SHIFT) begin
      // advance the removal one slot
      ctrl.op  = ilir_pkg::OP_SHIFT;
      ctrl.pos = shpos_q;
      rem_d    = rem_q - CNT_W'(1);
      if (rem_q == CNT_W'(1)) state_d = S_IDLE;
    end else if (take) begin
      case (req_i.req_type)
        ilir_pkg::REQ_APPEND: begin
          if (full) begin
            res_d.status = ilir_pkg::ST_FULL;
          end else begin
            ctrl.op  = ilir_pkg::OP_LOAD;
            ctrl.pos = ilir_pkg::POS_W'(count_q);
            count_d  = count_q + CNT_W'(1);
          end
        end
        ilir_pkg::REQ_INSERT: begin
          if (pos_x > cnt_x) begin
            res_d.status = ilir_pkg::ST_RANGE;
          end else if (full) begin
            res_d.status = ilir_pkg::ST_FULL;
          end else begin
            ctrl.op = ilir_pkg::OP_INSERT;
            count_d = count_q + CNT_W'(1);
          end
        end
        ilir_pkg::REQ_REMOVE: begin
          if (pos_x >= cnt_x || req_i.remove_count == '0) begin
            res_d.status = ilir_pkg::ST_RANGE;
          end else begin
            count_d = CNT_W'(cnt_x - k_x);
            rem_d   = CNT_W'(k_x);
            shpos_d = req_i.position;
            state_d = S_SHIFT;
          end
        end
        ilir_pkg::REQ_WRITE: begin
          if (pos_x >= cap_x) res_d.status = ilir_pkg::ST_RANGE;
          else ctrl.op = ilir_pkg::OP_LOAD;
        end
        ilir_pkg::REQ_READ: begin
          if (pos_x >= cnt_x) res_d.status = ilir_pkg::ST_RANGE;
          else res_d.read_word = rd_bus;
        end
        ilir_pkg::REQ_CLEAR: begin
          count_d = '0;
        end
        default: res_d.status = ilir_pkg::ST_RANGE;
      endcase
    end

    res_d.length_now = 5'(EXT_W'(count_d));
    res_d.is_empty   = (count_d == '0);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] lower, upper;
    if (g == 0) begin : g_lo_end
      assign lower = words[g];
    end else begin : g_lo
      assign lower = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_up_end
      assign upper = words[g];
    end else begin : g_up
      assign upper = words[g+1];
    end
    ilir_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .lower_i  (lower),
      .upper_i  (upper),
      .word_o   (words[g]),
      .rd_word_o(rd_words[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      res_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    shpos_q <= shpos_d;
    if (take) res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> res_valid_o) else $error("transfer without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> !res_valid_o) else $error("result without transfer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EXT_W'(count_q) <= EXT_W'(CAPACITY)) else $error("length past capacity");

  a_shift_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> rem_q != '0) else $error("shift with no steps left");

endmodule

/* design/ilir_cell.sv */
// One slot of the list: a word register that loads, takes its lower neighbor
// on insert, or takes its upper neighbor on a shift-down step. Uses ilir_pkg.

module ilir_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk_i,
  input  ilir_pkg::cell_ctrl_t           ctrl_i,
  input  logic [ilir_pkg::WORD_W-1:0]    lower_i,
  input  logic [ilir_pkg::WORD_W-1:0]    upper_i,
  output logic [ilir_pkg::WORD_W-1:0]    word_o,
  output logic [ilir_pkg::WORD_W-1:0]    rd_word_o
);

  localparam logic [ilir_pkg::POS_W-1:0] IdxPos = ilir_pkg::POS_W'(IDX);

  logic [ilir_pkg::WORD_W-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      ilir_pkg::OP_LOAD: begin
        if (ctrl_i.pos == IdxPos) word_d = ctrl_i.data;
      end
      ilir_pkg::OP_INSERT: begin
        if (IdxPos > ctrl_i.pos) word_d = lower_i;
        else if (IdxPos == ctrl_i.pos) word_d = ctrl_i.data;
      end
      ilir_pkg::OP_SHIFT: begin
        if (IdxPos >= ctrl_i.pos) word_d = upper_i;
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  // gate onto the read bus only when addressed
  assign rd_word_o = (ctrl_i.pos == IdxPos) ? word_q : '0;

endmodule
